FILE: rtl/apts_pkg.sv
`default_nettype none

package apts_pkg;

  // task table
  localparam int unsigned MAX_TASKS = 16;
  localparam int unsigned IDX_W     = $clog2(MAX_TASKS);
  localparam int unsigned CNT_W     = 5;

  // field widths
  localparam int unsigned TICK_W  = 32;
  localparam int unsigned AGE_W   = 16;
  localparam int unsigned PER_W   = 16;
  localparam int unsigned PRIO_W  = 10;
  localparam int unsigned SCORE_W = AGE_W + 1;

  // stream and config port widths
  localparam int unsigned IN_W      = 64;
  localparam int unsigned OUT_W     = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 16;

  localparam logic [PER_W-1:0] LIMIT_RST = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIODIC_CNT = 2'd0,
    CFG_IDLE_CNT     = 2'd1,
    CFG_OVF_LIMIT    = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ACT_NONE     = 2'd0,
    ACT_PERIODIC = 2'd1,
    ACT_IDLE     = 2'd2
  } action_e;

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_SCHED = 1'b1
  } mode_e;

  // counts above the table size act as the table size
  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] lim;
    lim = CNT_W'(MAX_TASKS);
    return (n > lim) ? lim : n;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/aging_priority_task_scheduler_unit.sv
// Flow: a load word or an abort pass goes from ST_IDLE to ST_DONE and then to the result
//   register; a scheduling pass over N active periodic entries visits them in ST_SCAN first.
// Pacing: no new word is taken until the result is registered, and ST_DONE waits while the
//   result register is full; the single age/score unit visits one task entry per cycle.
// Reset: asynchronous, active low; clears control, config (limit to 65535), idle pointer and
//   abort flag. The task table is not cleared and holds nothing until loaded.
`default_nettype none

module aging_priority_task_scheduler_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // input stream
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [31:0] now_ticks, [35:32] entry_index, [51:36] entry_period,
  // [61:52] entry_priority, [62] abort_request, [63] abortive_exception
  input  wire logic [apts_pkg::IN_W-1:0]       s_axis_tdata_i,
  // [0] mode
  input  wire logic                            s_axis_tuser_i,
  // result stream
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // [3:0] task_index, [4] overflow_fault, [5] run_abort_handlers, [7:6] zero
  output logic [apts_pkg::OUT_W-1:0]           m_axis_tdata_o,
  // [1:0] action
  output logic [1:0]                           m_axis_tuser_o,
  // config write port
  input  wire logic                            cfg_we_i,
  input  wire logic [apts_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [apts_pkg::CFG_W-1:0]      cfg_data_i
);

  localparam int unsigned IDX_W   = apts_pkg::IDX_W;
  localparam int unsigned CNT_W   = apts_pkg::CNT_W;
  localparam int unsigned TICK_W  = apts_pkg::TICK_W;
  localparam int unsigned AGE_W   = apts_pkg::AGE_W;
  localparam int unsigned PER_W   = apts_pkg::PER_W;
  localparam int unsigned PRIO_W  = apts_pkg::PRIO_W;
  localparam int unsigned SCORE_W = apts_pkg::SCORE_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // ---------------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] per_cnt_q;
  logic [CNT_W-1:0] idle_cnt_q;
  logic [PER_W-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      per_cnt_q  <= '0;
      idle_cnt_q <= '0;
      limit_q    <= apts_pkg::LIMIT_RST;
    end else if (cfg_we_i) begin
      case (apts_pkg::cfg_reg_e'(cfg_idx_i))
        apts_pkg::CFG_PERIODIC_CNT: per_cnt_q  <= cfg_data_i[CNT_W-1:0];
        apts_pkg::CFG_IDLE_CNT:     idle_cnt_q <= cfg_data_i[CNT_W-1:0];
        apts_pkg::CFG_OVF_LIMIT:    limit_q    <= cfg_data_i[PER_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Task table: one write port, one read port addressed by the scan counter
  // ---------------------------------------------------------------------------
  logic [TICK_W-1:0] stamp_mem  [apts_pkg::MAX_TASKS];
  logic [PER_W-1:0]  period_mem [apts_pkg::MAX_TASKS];
  logic [PRIO_W-1:0] prio_mem   [apts_pkg::MAX_TASKS];

  logic              stamp_we;
  logic              entry_we;      // period and priority too (load word)
  logic [IDX_W-1:0]  wr_idx;

  // latched input word
  apts_pkg::mode_e   mode_q;
  logic [TICK_W-1:0] now_q;
  logic [IDX_W-1:0]  eidx_q;
  logic [PER_W-1:0]  eper_q;
  logic [PRIO_W-1:0] eprio_q;
  logic              abort_q;       // abort request with abortive exception

  always_ff @(posedge clk_i) begin
    if (stamp_we) begin
      stamp_mem[wr_idx] <= now_q;
    end
    if (entry_we) begin
      period_mem[wr_idx] <= eper_q;
      prio_mem[wr_idx]   <= eprio_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  state_e            state_q;
  logic [CNT_W-1:0]  cnt_q;         // scan position
  logic [CNT_W-1:0]  scan_n_q;      // entries to visit this pass
  logic              found_q;
  logic [SCORE_W-1:0] best_q;
  logic [IDX_W-1:0]  win_q;
  logic              fault_q;
  logic [IDX_W-1:0]  idle_ptr_q;
  logic              abort_done_q;

  logic              out_valid_q;
  apts_pkg::action_e out_action_q;
  logic [IDX_W-1:0]  out_task_q;
  logic              out_fault_q;
  logic              out_handlers_q;

  logic in_fire;
  logic out_free;
  logic sched_pass;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  // output register empties or is taken this cycle
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign sched_pass      = (mode_q == apts_pkg::MODE_SCHED);

  // ---------------------------------------------------------------------------
  // Shared age/score unit: one entry per cycle
  // ---------------------------------------------------------------------------
  logic [IDX_W-1:0]   rd_idx;
  logic [TICK_W-1:0]  age;
  logic               age_fault;
  logic [AGE_W:0]     slack;        // 16-bit age minus period, with borrow
  logic               eligible;
  logic [SCORE_W-1:0] score;
  logic               better;

  always_comb begin
    rd_idx    = cnt_q[IDX_W-1:0];
    age       = now_q - stamp_mem[rd_idx];
    // any age beyond 16 bits is a fault whatever the limit
    age_fault = (age[TICK_W-1:AGE_W] != '0) || (age[AGE_W-1:0] > limit_q);
    slack     = {1'b0, age[AGE_W-1:0]} - {1'b0, period_mem[rd_idx]};
    eligible  = !slack[AGE_W] && (slack[AGE_W-1:0] != '0);
    score     = {1'b0, slack[AGE_W-1:0]} + SCORE_W'(prio_mem[rd_idx]);
    // strict compare keeps the lowest index on a tie
    better    = eligible && (!found_q || (score > best_q));
  end

  // ---------------------------------------------------------------------------
  // Idle round robin
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] idle_n;
  logic [IDX_W-1:0] idle_pick;
  logic [CNT_W-1:0] idle_inc;
  logic [IDX_W-1:0] idle_next;

  always_comb begin
    idle_n    = apts_pkg::clamp_count(idle_cnt_q);
    idle_pick = ({1'b0, idle_ptr_q} >= idle_n) ? '0 : idle_ptr_q;
    idle_inc  = {1'b0, idle_pick} + CNT_W'(1);
    idle_next = (idle_inc >= idle_n) ? '0 : idle_inc[IDX_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // Table writes, all at the end of an item
  // ---------------------------------------------------------------------------
  logic load_ok;

  always_comb begin
    load_ok  = ({1'b0, eidx_q} < CNT_W'(apts_pkg::MAX_TASKS));
    stamp_we = 1'b0;
    entry_we = 1'b0;
    wr_idx   = win_q;
    if ((state_q == ST_DONE) && out_free) begin
      if (mode_q == apts_pkg::MODE_LOAD) begin
        wr_idx   = eidx_q;
        stamp_we = load_ok;
        entry_we = load_ok;
      end else begin
        stamp_we = found_q;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input word capture
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q  <= apts_pkg::mode_e'(s_axis_tuser_i);
      now_q   <= s_axis_tdata_i[31:0];
      eidx_q  <= s_axis_tdata_i[35:32];
      eper_q  <= s_axis_tdata_i[51:36];
      eprio_q <= s_axis_tdata_i[61:52];
      abort_q <= s_axis_tdata_i[62] && s_axis_tdata_i[63];
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer and result register
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] scan_n_d;
  logic [CNT_W-1:0] cnt_inc;

  assign scan_n_d = apts_pkg::clamp_count(per_cnt_q);
  assign cnt_inc  = cnt_q + CNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      cnt_q          <= '0;
      scan_n_q       <= '0;
      found_q        <= 1'b0;
      best_q         <= '0;
      win_q          <= '0;
      fault_q        <= 1'b0;
      idle_ptr_q     <= '0;
      abort_done_q   <= 1'b0;
      out_valid_q    <= 1'b0;
      out_action_q   <= apts_pkg::ACT_NONE;
      out_task_q     <= '0;
      out_fault_q    <= 1'b0;
      out_handlers_q <= 1'b0;
    end else begin
      // in ST_DONE a taken word is replaced by the next one below
      if (out_valid_q && m_axis_tready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            cnt_q    <= '0;
            scan_n_q <= scan_n_d;
            found_q  <= 1'b0;
            best_q   <= '0;
            win_q    <= '0;
            fault_q  <= 1'b0;
            // scan only for a scheduling word without abort and with entries
            if ((apts_pkg::mode_e'(s_axis_tuser_i) == apts_pkg::MODE_SCHED) &&
                !(s_axis_tdata_i[62] && s_axis_tdata_i[63]) &&
                (scan_n_d != '0)) begin
              state_q <= ST_SCAN;
            end else begin
              state_q <= ST_DONE;
            end
          end
        end

        ST_SCAN: begin
          if (age_fault) begin
            fault_q <= 1'b1;
          end
          if (better) begin
            found_q <= 1'b1;
            best_q  <= score;
            win_q   <= rd_idx;
          end
          cnt_q <= cnt_inc;
          if (cnt_inc == scan_n_q) begin
            state_q <= ST_DONE;
          end
        end

        ST_DONE: begin
          if (out_free) begin
            out_valid_q    <= 1'b1;
            out_fault_q    <= sched_pass && fault_q;
            // handlers fire on the first abort pass only
            out_handlers_q <= sched_pass && abort_q && !abort_done_q;
            if (sched_pass && abort_q && !abort_done_q) begin
              abort_done_q <= 1'b1;
            end
            if (sched_pass && found_q) begin
              out_action_q <= apts_pkg::ACT_PERIODIC;
              out_task_q   <= win_q;
            end else if (sched_pass && (idle_n != '0)) begin
              out_action_q <= apts_pkg::ACT_IDLE;
              out_task_q   <= idle_pick;
              idle_ptr_q   <= idle_next;
            end else begin
              out_action_q <= apts_pkg::ACT_NONE;
              out_task_q   <= '0;
              if (sched_pass) begin
                idle_ptr_q <= '0;
              end
            end
            state_q <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_action_q;
  assign m_axis_tdata_o  = {2'b00, out_handlers_q, out_fault_q, out_task_q};

endmodule

`default_nettype wire
